>>> src/jsc_pkg.sv
// Shared types, phase codes and character helpers for the JSON object checker.
package jsc_pkg;

    localparam int DEFAULT_MAX_NESTING = 32;

    localparam int PHASE_W = 5;
    localparam int HEX_W   = 3;
    localparam int LIT_W   = 5;
    localparam int DEPTH_W = 6;

    localparam logic [PHASE_W-1:0] PH_TOP       = 5'd0;
    localparam logic [PHASE_W-1:0] PH_OBJ_FIRST = 5'd1;
    localparam logic [PHASE_W-1:0] PH_OBJ_KEY   = 5'd2;
    localparam logic [PHASE_W-1:0] PH_OBJ_COLON = 5'd3;
    localparam logic [PHASE_W-1:0] PH_VALUE     = 5'd4;
    localparam logic [PHASE_W-1:0] PH_ARR_FIRST = 5'd5;
    localparam logic [PHASE_W-1:0] PH_AFTER     = 5'd6;
    localparam logic [PHASE_W-1:0] PH_DONE      = 5'd7;
    localparam logic [PHASE_W-1:0] PH_KEY_STR   = 5'd8;
    localparam logic [PHASE_W-1:0] PH_KEY_ESC   = 5'd9;
    localparam logic [PHASE_W-1:0] PH_KEY_HEX   = 5'd10;
    localparam logic [PHASE_W-1:0] PH_VAL_STR   = 5'd11;
    localparam logic [PHASE_W-1:0] PH_VAL_ESC   = 5'd12;
    localparam logic [PHASE_W-1:0] PH_VAL_HEX   = 5'd13;
    localparam logic [PHASE_W-1:0] PH_NUM_MINUS = 5'd14;
    localparam logic [PHASE_W-1:0] PH_NUM_ZERO  = 5'd15;
    localparam logic [PHASE_W-1:0] PH_NUM_INT   = 5'd16;
    localparam logic [PHASE_W-1:0] PH_NUM_DOT   = 5'd17;
    localparam logic [PHASE_W-1:0] PH_NUM_FRAC  = 5'd18;
    localparam logic [PHASE_W-1:0] PH_NUM_E     = 5'd19;
    localparam logic [PHASE_W-1:0] PH_NUM_ESIGN = 5'd20;
    localparam logic [PHASE_W-1:0] PH_NUM_EDIG  = 5'd21;
    localparam logic [PHASE_W-1:0] PH_LIT       = 5'd22;

    localparam logic [1:0] VERDICT_PENDING  = 2'd0;
    localparam logic [1:0] VERDICT_VALID    = 2'd1;
    localparam logic [1:0] VERDICT_REJECTED = 2'd2;

    localparam logic KIND_OBJECT = 1'b0;
    localparam logic KIND_ARRAY  = 1'b1;

    // literal table positions: true 0..3, false 4..8, null 9..12
    localparam logic [LIT_W-1:0] LIT_TRUE_START  = 5'd1;
    localparam logic [LIT_W-1:0] LIT_FALSE_START = 5'd5;
    localparam logic [LIT_W-1:0] LIT_NULL_START  = 5'd10;
    localparam logic [LIT_W-1:0] LIT_TRUE_END    = 5'd4;
    localparam logic [LIT_W-1:0] LIT_FALSE_END   = 5'd9;
    localparam logic [LIT_W-1:0] LIT_NULL_END    = 5'd13;
    localparam logic [LIT_W-1:0] LIT_LEN         = 5'd13;

    localparam logic [HEX_W-1:0] HEX_DIGITS = 3'd4;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [HEX_W-1:0]   hex_left;
        logic [LIT_W-1:0]   lit_pos;
    } lex_state_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic kind;
    } stack_op_t;

    typedef struct packed {
        logic top_kind;
        logic empty;
        logic one;
        logic full;
    } stack_view_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
    endfunction

    function automatic logic [7:0] lit_char(input logic [LIT_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "t";
            5'd1:    c = "r";
            5'd2:    c = "u";
            5'd3:    c = "e";
            5'd4:    c = "f";
            5'd5:    c = "a";
            5'd6:    c = "l";
            5'd7:    c = "s";
            5'd8:    c = "e";
            5'd9:    c = "n";
            5'd10:   c = "u";
            5'd11:   c = "l";
            5'd12:   c = "l";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> src/jsc_byte_if.sv
// Input channel: one text byte per transfer.
interface jsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

>>> src/jsc_result_if.sv
// Output channel: one verdict per transfer.
interface jsc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;
    logic       document_done;
    logic [5:0] current_depth;

    modport source (output valid, output verdict, output document_done,
                    output current_depth, input ready);
    modport sink   (input valid, input verdict, input document_done,
                    input current_depth, output ready);
endinterface

>>> src/json_object_syntax_checker.sv
// Streaming JSON object syntax checker: a byte stream in, one verdict per byte out, with the
// container kinds held in a shift-register stack of MAX_NESTING entries.
// One byte is taken every clock cycle and its result appears in the result register in the
// following cycle; the rate is set by the combinational grammar step from the lexer and stack
// registers into the result register. The input is stalled only while a result waits to be
// taken. A byte with end_of_text set closes the document and clears all state for the next
// one; after a rejection later bytes of the document are ignored and the depth holds.
module json_object_syntax_checker
    import jsc_pkg::*;
#(
    parameter int MAX_NESTING = DEFAULT_MAX_NESTING
)
(
    input logic          clk,
    input logic          rst_n,
    jsc_byte_if.sink     byte_ch,
    jsc_result_if.source result_ch
);

    localparam int CNT_W = $clog2(MAX_NESTING + 1);

    logic [MAX_NESTING-1:0] stack_reg;
    logic [MAX_NESTING-1:0] stack_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    lex_state_t             lex_reg;
    lex_state_t             lex_next;
    logic                   rejected_reg;

    logic                   out_valid_reg;
    logic [1:0]             verdict_reg;
    logic                   done_reg;
    logic [DEPTH_W-1:0]     depth_reg;

    stack_view_t            view;
    stack_op_t              op;
    logic                   step_reject;
    logic                   transfer;
    logic                   hold;
    logic [MAX_NESTING:0]   push_ext;
    logic [MAX_NESTING:0]   pop_ext;
    logic [CNT_W-1:0]       count_after;
    logic [PHASE_W-1:0]     phase_after;
    logic [1:0]             verdict_next;

    assign byte_ch.ready = !out_valid_reg || result_ch.ready;
    assign transfer      = byte_ch.valid && byte_ch.ready;

    assign view.top_kind = stack_reg[0];
    assign view.empty    = (count_reg == '0);
    assign view.one      = (count_reg == CNT_W'(1));
    assign view.full     = (count_reg >= CNT_W'(MAX_NESTING));

    jsc_lexer u_lexer (
        .state     (lex_reg),
        .text_byte (byte_ch.text_byte),
        .view      (view),
        .next      (lex_next),
        .op        (op),
        .reject    (step_reject)
    );

    // top of stack sits at bit 0: push shifts up, pop shifts down
    assign push_ext = {stack_reg, op.kind};
    assign pop_ext  = {1'b0, stack_reg};

    always_comb
    begin
        if (op.push) begin
            stack_next = push_ext[MAX_NESTING-1:0];
            count_next = count_reg + CNT_W'(1);
        end else if (op.pop) begin
            stack_next = pop_ext[MAX_NESTING:1];
            count_next = count_reg - CNT_W'(1);
        end else begin
            stack_next = stack_reg;
            count_next = count_reg;
        end
    end

    // a rejected byte leaves the state as it was
    assign hold        = rejected_reg || step_reject;
    assign count_after = hold ? count_reg : count_next;
    assign phase_after = hold ? lex_reg.phase : lex_next.phase;

    always_comb
    begin
        if (hold) begin
            verdict_next = VERDICT_REJECTED;
        end else if (phase_after == PH_DONE) begin
            verdict_next = VERDICT_VALID;
        end else if (byte_ch.end_of_text) begin
            verdict_next = VERDICT_REJECTED;
        end else begin
            verdict_next = VERDICT_PENDING;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stack_reg    <= '0;
            count_reg    <= '0;
            lex_reg      <= '{phase: PH_TOP, hex_left: '0, lit_pos: '0};
            rejected_reg <= 1'b0;
        end else if (transfer) begin
            if (byte_ch.end_of_text) begin
                stack_reg    <= '0;
                count_reg    <= '0;
                lex_reg      <= '{phase: PH_TOP, hex_left: '0, lit_pos: '0};
                rejected_reg <= 1'b0;
            end else if (!rejected_reg) begin
                if (step_reject) begin
                    rejected_reg <= 1'b1;
                end else begin
                    stack_reg <= stack_next;
                    count_reg <= count_next;
                    lex_reg   <= lex_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (transfer) begin
            out_valid_reg <= 1'b1;
        end else if (result_ch.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (transfer) begin
            verdict_reg <= verdict_next;
            done_reg    <= byte_ch.end_of_text;
            depth_reg   <= DEPTH_W'(count_after);
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.verdict       = verdict_reg;
    assign result_ch.document_done = done_reg;
    assign result_ch.current_depth = depth_reg;

endmodule

>>> src/jsc_lexer.sv
// Next-state logic of the JSON grammar for one byte.
module jsc_lexer
    import jsc_pkg::*;
(
    input  lex_state_t  state,
    input  logic [7:0]  text_byte,
    input  stack_view_t view,
    output lex_state_t  next,
    output stack_op_t   op,
    output logic        reject
);

    typedef struct packed {
        lex_state_t st;
        stack_op_t  op;
        logic       rej;
    } step_t;

    function automatic step_t open_c(input step_t s, input logic kind, input stack_view_t v);
        step_t r;
        r = s;
        if (v.full) begin
            r.rej = 1'b1;
        end else begin
            r.op.push   = 1'b1;
            r.op.kind   = kind;
            r.st.phase  = (kind == KIND_ARRAY) ? PH_ARR_FIRST : PH_OBJ_FIRST;
        end
        return r;
    endfunction

    function automatic step_t close_c(input step_t s, input logic kind, input stack_view_t v);
        step_t r;
        r = s;
        if (v.empty || (v.top_kind != kind)) begin
            r.rej = 1'b1;
        end else begin
            r.op.pop   = 1'b1;
            r.st.phase = v.one ? PH_DONE : PH_AFTER;
        end
        return r;
    endfunction

    function automatic step_t start_value(input step_t s, input logic [7:0] b,
                                          input stack_view_t v);
        step_t r;
        r = s;
        if (b == "{") begin
            r = open_c(s, KIND_OBJECT, v);
        end else if (b == "[") begin
            r = open_c(s, KIND_ARRAY, v);
        end else if (b == "\"") begin
            r.st.phase = PH_VAL_STR;
        end else if (b == "-") begin
            r.st.phase = PH_NUM_MINUS;
        end else if (b == "0") begin
            r.st.phase = PH_NUM_ZERO;
        end else if (is_digit(b)) begin
            r.st.phase = PH_NUM_INT;
        end else if (b == "t") begin
            r.st.lit_pos = LIT_TRUE_START;
            r.st.phase   = PH_LIT;
        end else if (b == "f") begin
            r.st.lit_pos = LIT_FALSE_START;
            r.st.phase   = PH_LIT;
        end else if (b == "n") begin
            r.st.lit_pos = LIT_NULL_START;
            r.st.phase   = PH_LIT;
        end else begin
            r.rej = 1'b1;
        end
        return r;
    endfunction

    function automatic step_t after_value(input step_t s, input logic [7:0] b,
                                          input stack_view_t v);
        step_t r;
        r = s;
        r.st.phase = PH_AFTER;
        if (is_ws(b)) begin
            r.st.phase = PH_AFTER;
        end else if (b == ",") begin
            if (v.empty) begin
                r.rej = 1'b1;
            end else begin
                r.st.phase = (v.top_kind == KIND_ARRAY) ? PH_VALUE : PH_OBJ_KEY;
            end
        end else if (b == "}") begin
            r = close_c(r, KIND_OBJECT, v);
        end else if (b == "]") begin
            r = close_c(r, KIND_ARRAY, v);
        end else begin
            r.rej = 1'b1;
        end
        return r;
    endfunction

    function automatic step_t string_byte(input step_t s, input logic [7:0] b,
                                          input logic [PHASE_W-1:0] esc_ph,
                                          input logic [PHASE_W-1:0] done_ph);
        step_t r;
        r = s;
        if (b == "\"") begin
            r.st.phase = done_ph;
        end else if (b == "\\") begin
            r.st.phase = esc_ph;
        end else if (b < 8'h20) begin
            r.rej = 1'b1;
        end
        return r;
    endfunction

    function automatic step_t escape_byte(input step_t s, input logic [7:0] b,
                                          input logic [PHASE_W-1:0] str_ph,
                                          input logic [PHASE_W-1:0] hex_ph);
        step_t r;
        r = s;
        if ((b == "\"") || (b == "\\") || (b == "/") || (b == "b") || (b == "f") ||
            (b == "n") || (b == "r") || (b == "t")) begin
            r.st.phase = str_ph;
        end else if (b == "u") begin
            r.st.hex_left = HEX_DIGITS;
            r.st.phase    = hex_ph;
        end else begin
            r.rej = 1'b1;
        end
        return r;
    endfunction

    function automatic step_t hex_byte(input step_t s, input logic [7:0] b,
                                       input logic [PHASE_W-1:0] str_ph);
        step_t r;
        r = s;
        if (!is_hex(b) || (s.st.hex_left == '0)) begin
            r.rej = 1'b1;
        end else begin
            r.st.hex_left = s.st.hex_left - HEX_W'(1);
            if (s.st.hex_left == HEX_W'(1)) begin
                r.st.phase = str_ph;
            end
        end
        return r;
    endfunction

    function automatic step_t lit_byte(input step_t s, input logic [7:0] b);
        step_t            r;
        logic [LIT_W-1:0] pos;
        r   = s;
        pos = s.st.lit_pos + LIT_W'(1);
        if ((s.st.lit_pos >= LIT_LEN) || (lit_char(s.st.lit_pos) != b)) begin
            r.rej = 1'b1;
        end else if ((pos == LIT_TRUE_END) || (pos == LIT_FALSE_END) ||
                     (pos == LIT_NULL_END)) begin
            r.st.lit_pos = '0;
            r.st.phase   = PH_AFTER;
        end else begin
            r.st.lit_pos = pos;
        end
        return r;
    endfunction

    step_t s0;
    step_t s;

    always_comb
    begin
        s0.st  = state;
        s0.op  = '0;
        s0.rej = 1'b0;
        s      = s0;
        case (state.phase)
            PH_TOP:
            begin
                if (text_byte == "{") s = open_c(s0, KIND_OBJECT, view);
                else if (!is_ws(text_byte)) s.rej = 1'b1;
            end
            PH_OBJ_FIRST:
            begin
                if (text_byte == "\"") s.st.phase = PH_KEY_STR;
                else if (text_byte == "}") s = close_c(s0, KIND_OBJECT, view);
                else if (!is_ws(text_byte)) s.rej = 1'b1;
            end
            PH_OBJ_KEY:
            begin
                if (text_byte == "\"") s.st.phase = PH_KEY_STR;
                else if (!is_ws(text_byte)) s.rej = 1'b1;
            end
            PH_OBJ_COLON:
            begin
                if (text_byte == ":") s.st.phase = PH_VALUE;
                else if (!is_ws(text_byte)) s.rej = 1'b1;
            end
            PH_VALUE:
            begin
                if (!is_ws(text_byte)) s = start_value(s0, text_byte, view);
            end
            PH_ARR_FIRST:
            begin
                if (text_byte == "]") s = close_c(s0, KIND_ARRAY, view);
                else if (!is_ws(text_byte)) s = start_value(s0, text_byte, view);
            end
            PH_AFTER:     s = after_value(s0, text_byte, view);
            PH_DONE:
            begin
                if (!is_ws(text_byte)) s.rej = 1'b1;
            end
            PH_KEY_STR:   s = string_byte(s0, text_byte, PH_KEY_ESC, PH_OBJ_COLON);
            PH_KEY_ESC:   s = escape_byte(s0, text_byte, PH_KEY_STR, PH_KEY_HEX);
            PH_KEY_HEX:   s = hex_byte(s0, text_byte, PH_KEY_STR);
            PH_VAL_STR:   s = string_byte(s0, text_byte, PH_VAL_ESC, PH_AFTER);
            PH_VAL_ESC:   s = escape_byte(s0, text_byte, PH_VAL_STR, PH_VAL_HEX);
            PH_VAL_HEX:   s = hex_byte(s0, text_byte, PH_VAL_STR);
            PH_NUM_MINUS:
            begin
                if (text_byte == "0") s.st.phase = PH_NUM_ZERO;
                else if (is_digit(text_byte)) s.st.phase = PH_NUM_INT;
                else s.rej = 1'b1;
            end
            PH_NUM_ZERO:
            begin
                if (text_byte == ".") s.st.phase = PH_NUM_DOT;
                else if ((text_byte == "e") || (text_byte == "E")) s.st.phase = PH_NUM_E;
                else if (is_digit(text_byte)) s.rej = 1'b1;
                else s = after_value(s0, text_byte, view);
            end
            PH_NUM_INT:
            begin
                if (is_digit(text_byte)) s = s0;
                else if (text_byte == ".") s.st.phase = PH_NUM_DOT;
                else if ((text_byte == "e") || (text_byte == "E")) s.st.phase = PH_NUM_E;
                else s = after_value(s0, text_byte, view);
            end
            PH_NUM_DOT:
            begin
                if (is_digit(text_byte)) s.st.phase = PH_NUM_FRAC;
                else s.rej = 1'b1;
            end
            PH_NUM_FRAC:
            begin
                if (is_digit(text_byte)) s = s0;
                else if ((text_byte == "e") || (text_byte == "E")) s.st.phase = PH_NUM_E;
                else s = after_value(s0, text_byte, view);
            end
            PH_NUM_E:
            begin
                if ((text_byte == "+") || (text_byte == "-")) s.st.phase = PH_NUM_ESIGN;
                else if (is_digit(text_byte)) s.st.phase = PH_NUM_EDIG;
                else s.rej = 1'b1;
            end
            PH_NUM_ESIGN:
            begin
                if (is_digit(text_byte)) s.st.phase = PH_NUM_EDIG;
                else s.rej = 1'b1;
            end
            PH_NUM_EDIG:
            begin
                if (!is_digit(text_byte)) s = after_value(s0, text_byte, view);
            end
            PH_LIT:       s = lit_byte(s0, text_byte);
            default:      s.rej = 1'b1;
        endcase
    end

    assign next   = s.st;
    assign op     = s.op;
    assign reject = s.rej;

endmodule

>>> src/jsc_checker.sv
// Port-level assertions for the JSON object checker, bound to the top level.
module jsc_checker
    import jsc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] verdict,
    input logic       document_done,
    input logic [5:0] current_depth
);

    // every byte transfer produces a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("byte transfer not followed by a result");

    // input stalls only behind a result that is not being taken
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a pending result");

    // a closing result carries a final verdict
    a_final_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && document_done) |->
            ((verdict == VERDICT_VALID) || (verdict == VERDICT_REJECTED)))
        else $error("document closed with a pending verdict");

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(verdict) && $stable(document_done) &&
             $stable(current_depth)))
        else $error("stalled result changed");

endmodule

bind json_object_syntax_checker jsc_checker u_jsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (byte_ch.valid),
    .in_ready      (byte_ch.ready),
    .out_valid     (result_ch.valid),
    .out_ready     (result_ch.ready),
    .verdict       (result_ch.verdict),
    .document_done (result_ch.document_done),
    .current_depth (result_ch.current_depth)
);
